/* rtl/sspw_pkg.sv */
// Shared types and constants for the step sequencer position walker.
// No dependencies; imported by every module of the block.
package sspw_pkg;

  localparam int STEPS = 16;

  // Sixteen steps and the signed 6-bit step register.
  localparam int STEP_W  = 4;
  localparam int POS_W   = 6;
  localparam int CFG_W   = 5;

  // Wide enough for any intermediate of a step move.
  localparam int CALC_W  = 9;

  localparam int APB_DW  = 32;
  localparam int APB_AW  = 4;

  typedef enum logic [1:0] {
    CMD_LOOP_START = 2'd0,
    CMD_TICK       = 2'd1,
    CMD_REALIGN    = 2'd2,
    CMD_NONE       = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    REG_STRIDE        = 2'd0,
    REG_WINDOW_SHIFT  = 2'd1,
    REG_WINDOW_LENGTH = 2'd2,
    REG_FOLD_ENABLE   = 2'd3
  } cfg_reg_t;

  localparam logic [CFG_W-1:0] STRIDE_RST = 5'd1;
  localparam logic [CFG_W-1:0] SHIFT_RST  = 5'd0;
  localparam logic [CFG_W-1:0] LENGTH_RST = 5'd16;

  typedef struct packed {
    logic [CFG_W-1:0]        stride;
    logic signed [CFG_W-1:0] window_shift;
    logic [CFG_W-1:0]        window_length;
    logic                    fold_enable;
  } cfg_t;

  typedef struct packed {
    logic                    armed;
    logic signed [POS_W-1:0] position;
    logic                    going_back;
    logic [STEP_W-1:0]       window_start;
    logic [STEP_W-1:0]       tick_count;
  } walk_state_t;

endpackage

/* rtl/sspw_cfg_regs.sv */
// Configuration register file with APB-style access.
// Depends on sspw_pkg for the register map and the cfg_t struct.
module sspw_cfg_regs
  import sspw_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready,
  output cfg_t              cfg,
  output logic              fold_wr
);

  logic     wr_en;
  cfg_reg_t idx;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign idx    = cfg_reg_t'(paddr[APB_AW-1:2]);
  // writing fold also turns the walk forward
  assign fold_wr = wr_en && (idx == REG_FOLD_ENABLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.stride        <= STRIDE_RST;
      cfg.window_shift  <= SHIFT_RST;
      cfg.window_length <= LENGTH_RST;
      cfg.fold_enable   <= 1'b0;
    end else if (wr_en) begin
      case (idx)
        REG_STRIDE:        cfg.stride        <= pwdata[CFG_W-1:0];
        REG_WINDOW_SHIFT:  cfg.window_shift  <= pwdata[CFG_W-1:0];
        REG_WINDOW_LENGTH: cfg.window_length <= pwdata[CFG_W-1:0];
        REG_FOLD_ENABLE:   cfg.fold_enable   <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    case (idx)
      REG_STRIDE:        prdata[CFG_W-1:0] = cfg.stride;
      REG_WINDOW_SHIFT:  prdata[CFG_W-1:0] = cfg.window_shift;
      REG_WINDOW_LENGTH: prdata[CFG_W-1:0] = cfg.window_length;
      REG_FOLD_ENABLE:   prdata[0]         = cfg.fold_enable;
      default:           prdata = '0;
    endcase
  end

endmodule

/* rtl/sspw_step_core.sv */
// Next-state logic of the walker: one request against the current state.
// Depends on sspw_pkg for cmd_t, cfg_t and walk_state_t.
module sspw_step_core
  import sspw_pkg::*;
(
  input  walk_state_t       cur,
  input  cfg_t              cfg,
  input  cmd_t              cmd,
  input  logic [STEP_W-1:0] align_step,
  output walk_state_t       nxt
);

  localparam logic signed [CALC_W-1:0] STEPS_C = CALC_W'(STEPS);

  logic [CFG_W-1:0]         len;
  logic signed [CALC_W-1:0] ws_w;
  logic signed [CALC_W-1:0] end_w;
  logic signed [CALC_W-1:0] moved;
  logic signed [CALC_W-1:0] over;
  logic signed [CALC_W-1:0] bounded;
  logic signed [CALC_W-1:0] folded;
  logic                     back_next;
  logic [CFG_W-1:0]         cnt_inc;
  logic signed [CFG_W:0]    ws_shift;
  walk_state_t              ticked;

  always_comb begin
    // length clamped into 1..16
    if (cfg.window_length == '0) begin
      len = CFG_W'(1);
    end else if (cfg.window_length > CFG_W'(STEPS)) begin
      len = CFG_W'(STEPS);
    end else begin
      len = cfg.window_length;
    end

    ws_w  = CALC_W'({1'b0, cur.window_start});
    end_w = ws_w + CALC_W'({1'b0, len});
    if (cur.going_back) begin
      moved = CALC_W'(cur.position) - CALC_W'({1'b0, cfg.stride});
    end else begin
      moved = CALC_W'(cur.position) + CALC_W'({1'b0, cfg.stride});
    end

    back_next = cur.going_back;
    over      = '0;
    bounded   = moved;
    if (moved < ws_w || moved < 0) begin
      over = ws_w - moved;
      if (cfg.fold_enable) begin
        bounded   = ws_w + over;
        back_next = 1'b0;
      end else begin
        bounded = end_w - over - CALC_W'(1);
      end
    end else if (moved >= STEPS_C || moved >= end_w) begin
      over = (moved >= STEPS_C) ? moved - STEPS_C : moved - end_w;
      if (cfg.fold_enable) begin
        bounded   = end_w - over - CALC_W'(1);
        back_next = 1'b1;
      end else begin
        bounded = ws_w + over;
      end
    end

    // a single add or subtract of 16 toward 0..15, then kept as 6-bit two's complement
    if (bounded >= STEPS_C) begin
      folded = bounded - STEPS_C;
    end else if (bounded < 0) begin
      folded = bounded + STEPS_C;
    end else begin
      folded = bounded;
    end

    ticked            = cur;
    ticked.position   = folded[POS_W-1:0];
    ticked.going_back = back_next;
    cnt_inc  = CFG_W'({1'b0, cur.tick_count}) + CFG_W'(1);
    ws_shift = (CFG_W+1)'({1'b0, cur.window_start}) + (CFG_W+1)'(cfg.window_shift);
    if (cnt_inc >= len) begin
      ticked.tick_count = '0;
      // sum lies in -16..30, so the low bits are the value mod 16
      ticked.window_start = ws_shift[STEP_W-1:0];
    end else begin
      ticked.tick_count = cnt_inc[STEP_W-1:0];
    end

    nxt = cur;
    case (cmd)
      CMD_LOOP_START: nxt.armed = 1'b1;
      CMD_TICK: begin
        if (cur.armed) begin
          nxt = ticked;
        end
      end
      CMD_REALIGN:    nxt.position = POS_W'({1'b0, align_step});
      default: ;
    endcase
  end

endmodule

/* rtl/step_sequencer_position_walker.sv */
// Step sequencer position walker, top level.
// Depends on sspw_pkg, sspw_cfg_regs and sspw_step_core.
//
// Takes one request per clock while s_tready is high (s_tuser = command,
// s_tdata = sixteenth for realign) and returns one result per request:
// the input register holds it, then the state update loads the state and
// result registers, which move with the input register, so full throughput
// holds while m_tready stays high. The user must write registers over the
// APB port only while no request is in flight; the block does not enforce
// it. Writing fold_enable turns the walk forward again.
module step_sequencer_position_walker
  import sspw_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              s_tvalid,
  output logic              s_tready,
  input  logic [7:0]        s_tdata,   // [3:0] align_step, [7:4] zero
  input  logic [1:0]        s_tuser,   // [1:0] cmd
  output logic              m_tvalid,
  input  logic              m_tready,
  output logic [15:0]       m_tdata,   // [5:0] step, [9:6] window_start_out,
                                       // [10] backward, [11] running, [15:12] zero
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready
);

  cfg_t              cfg;
  logic              fold_wr;
  logic              in_valid;
  cmd_t              in_cmd;
  logic [STEP_W-1:0] in_align;
  logic              advance;
  walk_state_t       state;
  walk_state_t       state_next;
  logic [15:0]       result;

  sspw_cfg_regs u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg),
    .fold_wr (fold_wr)
  );

  sspw_step_core u_core (
    .cur        (state),
    .cfg        (cfg),
    .cmd        (in_cmd),
    .align_step (in_align),
    .nxt        (state_next)
  );

  assign advance  = in_valid && (!m_tvalid || m_tready);
  assign s_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_cmd   <= cmd_t'(s_tuser);
      in_align <= s_tdata[STEP_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= '0;
      m_tvalid <= 1'b0;
    end else begin
      if (advance) begin
        state    <= state_next;
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      if (fold_wr) begin
        state.going_back <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      result <= {4'b0, state_next.armed, state_next.going_back,
                 state_next.window_start, state_next.position};
    end
  end

  assign m_tdata = result;

endmodule
